### hw/rtl/amgt_pkg.sv
// ----------------------------------------------------------------------------
// amgt_pkg
// Shared widths, codes and types of the adjacency matrix graph traversal block.
// ----------------------------------------------------------------------------
package amgt_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int VW         = 6;   // vertex field
    localparam int DW         = 6;   // distance field
    localparam int KW         = 2;   // kind field
    localparam int VCW        = 7;   // vertex count register
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [KW-1:0] {
        K_ADD_EDGE = 2'd0,
        K_TRAVERSE = 2'd1,
        K_CLEAR    = 2'd2
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVERSAL_MODE = 1'd1;

    localparam logic [VCW-1:0] VCOUNT_RST = 7'd64;
    localparam logic           MODE_BFS   = 1'b0;
    localparam logic           MODE_DFS   = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_START = 1'b1;

    // one queue or stack entry
    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [DW-1:0] distance;
    } t_entry;

    // request from the sequencer to the result buffer
    typedef struct packed {
        logic          push;
        logic          flush;
        logic [VW-1:0] vertex;
        logic [DW-1:0] distance;
        logic          status;
    } t_res_req;

endpackage

### hw/rtl/adjacency_matrix_graph_traversal.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_traversal
// Undirected graph in an adjacency row memory; breadth-first or depth-first
// walk from a start vertex, one result word per visited vertex.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_stall   i_kind i_vertex_a i_vertex_b
//  out       source     o_out_valid / i_out_stall o_vertex o_distance o_last o_status
//  cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
//  Add edge is a read-modify-write of two rows through the one row memory,
//  clear resets its row valid bits, a bad start sends one status word.
//  Breadth-first: per visited vertex a list read, a row read and a candidate
//  latch, then one enqueue a cycle per discovered vertex.
//  Depth-first: a row read per discovered vertex; backtrack reads stack top, then row.
//  Reset is synchronous; the matrix is empty right after reset.
//  A stall on the output channel holds the walk once two words are pending.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_traversal #(
    parameter int MAX_VERTICES = amgt_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [amgt_pkg::KW-1:0]           i_kind,
    input  logic [amgt_pkg::VW-1:0]           i_vertex_a,
    input  logic [amgt_pkg::VW-1:0]           i_vertex_b,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [amgt_pkg::VW-1:0]           o_vertex,
    output logic [amgt_pkg::DW-1:0]           o_distance,
    output logic                              o_last,
    output logic                              o_status,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [amgt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [amgt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import amgt_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int PW = $clog2(MAX_VERTICES + 1);
    localparam logic [VCW-1:0]          MAXV = VCW'(MAX_VERTICES);
    localparam logic [MAX_VERTICES-1:0] ONE  = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_EDGE_A  = 13'b0000000000010,
        S_EDGE_B  = 13'b0000000000100,
        S_BAD     = 13'b0000000001000,
        S_FIN     = 13'b0000000010000,
        S_B_START = 13'b0000000100000,
        S_B_POP   = 13'b0000001000000,
        S_B_ROW   = 13'b0000010000000,
        S_B_CAND  = 13'b0000100000000,
        S_B_SCAN  = 13'b0001000000000,
        S_D_START = 13'b0010000000000,
        S_D_FIND  = 13'b0100000000000,
        S_D_TOP   = 13'b1000000000000
    } t_state;

    function automatic logic [AW-1:0] f_lowest(input logic [MAX_VERTICES-1:0] v);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = AW'(i);
            end
        end
        return idx;
    endfunction

    // configuration registers
    logic [VCW-1:0] r_vcount;
    logic           r_tmode;

    // sequencer state
    t_state                  r_state,    n_state;
    logic [AW-1:0]           r_a,        n_a;
    logic [AW-1:0]           r_b,        n_b;
    logic [AW-1:0]           r_start,    n_start;
    logic [MAX_VERTICES-1:0] r_cnt_mask, n_cnt_mask;
    logic [MAX_VERTICES-1:0] r_visited,  n_visited;
    logic [MAX_VERTICES-1:0] r_cand,     n_cand;
    logic [DW-1:0]           r_cur_d,    n_cur_d;
    logic [PW-1:0]           r_head,     n_head;
    logic [PW-1:0]           r_tail,     n_tail;
    logic [PW-1:0]           r_height,   n_height;

    // memory ports
    logic                    adj_re, adj_we, adj_clr;
    logic [AW-1:0]           adj_raddr, adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
    logic                    lst_re, lst_we;
    logic [AW-1:0]           lst_raddr, lst_waddr;
    t_entry                  lst_wdata, lst_rdata;

    t_res_req                res_req;
    logic                    res_room;

    logic [VCW-1:0]          eff_count;
    logic [MAX_VERTICES-1:0] cnt_mask;
    logic [MAX_VERTICES-1:0] dfs_cand;
    logic [AW-1:0]           bfs_idx, dfs_idx;
    logic                    in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        eff_count = (r_vcount > MAXV) ? MAXV : r_vcount;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            cnt_mask[i] = (VCW'(i) < eff_count);
        end
    end

    assign dfs_cand = adj_rdata & r_cnt_mask & ~r_visited;
    assign bfs_idx  = f_lowest(r_cand);
    assign dfs_idx  = f_lowest(dfs_cand);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RST;
            r_tmode  <= MODE_BFS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_VERTEX_COUNT:   r_vcount <= i_cfg_data;
                REG_TRAVERSAL_MODE: r_tmode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_a        = r_a;
        n_b        = r_b;
        n_start    = r_start;
        n_cnt_mask = r_cnt_mask;
        n_visited  = r_visited;
        n_cand     = r_cand;
        n_cur_d    = r_cur_d;
        n_head     = r_head;
        n_tail     = r_tail;
        n_height   = r_height;
        adj_re     = 1'b0;
        adj_raddr  = '0;
        adj_we     = 1'b0;
        adj_waddr  = '0;
        adj_wdata  = '0;
        adj_clr    = 1'b0;
        lst_re     = 1'b0;
        lst_raddr  = '0;
        lst_we     = 1'b0;
        lst_waddr  = '0;
        lst_wdata  = '0;
        res_req    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_kind'(i_kind))
                        K_ADD_EDGE: begin
                            // drop edges with an endpoint outside the matrix
                            if (VCW'(i_vertex_a) < MAXV && VCW'(i_vertex_b) < MAXV) begin
                                adj_re    = 1'b1;
                                adj_raddr = i_vertex_a[AW-1:0];
                                n_a       = i_vertex_a[AW-1:0];
                                n_b       = i_vertex_b[AW-1:0];
                                n_state   = S_EDGE_A;
                            end
                        end
                        K_TRAVERSE: begin
                            n_cnt_mask = cnt_mask;
                            if (VCW'(i_vertex_a) >= eff_count) begin
                                n_state = S_BAD;
                            end else begin
                                n_start = i_vertex_a[AW-1:0];
                                n_state = (r_tmode == MODE_DFS) ? S_D_START : S_B_START;
                            end
                        end
                        K_CLEAR: begin
                            adj_clr = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            S_EDGE_A: begin
                adj_we    = 1'b1;
                adj_waddr = r_a;
                adj_wdata = adj_rdata | (ONE << r_b);
                adj_re    = 1'b1;
                adj_raddr = r_b;
                n_state   = S_EDGE_B;
            end

            S_EDGE_B: begin
                // a self loop reads the old row here, but the bit is the same
                adj_we    = 1'b1;
                adj_waddr = r_b;
                adj_wdata = adj_rdata | (ONE << r_a);
                n_state   = S_IDLE;
            end

            S_BAD: begin
                if (res_room) begin
                    res_req.push   = 1'b1;
                    res_req.status = STATUS_BAD_START;
                    n_state        = S_FIN;
                end
            end

            S_FIN: begin
                if (res_room) begin
                    res_req.flush = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            S_B_START: begin
                n_visited          = ONE << r_start;
                lst_we             = 1'b1;
                lst_wdata.vertex   = VW'(r_start);
                lst_wdata.distance = '0;
                n_head             = '0;
                n_tail             = PW'(1);
                n_state            = S_B_POP;
            end

            S_B_POP: begin
                if (r_head < r_tail) begin
                    lst_re    = 1'b1;
                    lst_raddr = r_head[AW-1:0];
                    n_head    = r_head + PW'(1);
                    n_state   = S_B_ROW;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_B_ROW: begin
                if (res_room) begin
                    res_req.push     = 1'b1;
                    res_req.vertex   = lst_rdata.vertex;
                    res_req.distance = lst_rdata.distance;
                    res_req.status   = STATUS_OK;
                    n_cur_d          = lst_rdata.distance;
                    adj_re           = 1'b1;
                    adj_raddr        = lst_rdata.vertex[AW-1:0];
                    n_state          = S_B_CAND;
                end
            end

            S_B_CAND: begin
                n_cand  = adj_rdata & r_cnt_mask & ~r_visited;
                n_state = S_B_SCAN;
            end

            S_B_SCAN: begin
                // enqueue one neighbor a cycle, lowest index first
                if (|r_cand) begin
                    lst_we             = 1'b1;
                    lst_waddr          = r_tail[AW-1:0];
                    lst_wdata.vertex   = VW'(bfs_idx);
                    lst_wdata.distance = r_cur_d + DW'(1);
                    n_tail             = r_tail + PW'(1);
                    n_visited          = r_visited | (ONE << bfs_idx);
                    n_cand             = r_cand & ~(ONE << bfs_idx);
                end else begin
                    n_state = S_B_POP;
                end
            end

            S_D_START: begin
                if (res_room) begin
                    res_req.push       = 1'b1;
                    res_req.vertex     = VW'(r_start);
                    res_req.status     = STATUS_OK;
                    n_visited          = ONE << r_start;
                    lst_we             = 1'b1;
                    lst_wdata.vertex   = VW'(r_start);
                    lst_wdata.distance = '0;
                    n_height           = PW'(1);
                    adj_re             = 1'b1;
                    adj_raddr          = r_start;
                    n_state            = S_D_FIND;
                end
            end

            S_D_FIND: begin
                if (|dfs_cand) begin
                    // descend into the lowest unvisited neighbor
                    if (res_room) begin
                        res_req.push       = 1'b1;
                        res_req.vertex     = VW'(dfs_idx);
                        res_req.distance   = DW'(r_height);
                        res_req.status     = STATUS_OK;
                        n_visited          = r_visited | (ONE << dfs_idx);
                        lst_we             = 1'b1;
                        lst_waddr          = r_height[AW-1:0];
                        lst_wdata.vertex   = VW'(dfs_idx);
                        lst_wdata.distance = DW'(r_height);
                        n_height           = r_height + PW'(1);
                        adj_re             = 1'b1;
                        adj_raddr          = dfs_idx;
                    end
                end else begin
                    // backtrack
                    n_height = r_height - PW'(1);
                    if (r_height == PW'(1)) begin
                        n_state = S_FIN;
                    end else begin
                        lst_re    = 1'b1;
                        lst_raddr = AW'(r_height - PW'(2));
                        n_state   = S_D_TOP;
                    end
                end
            end

            S_D_TOP: begin
                adj_re    = 1'b1;
                adj_raddr = lst_rdata.vertex[AW-1:0];
                n_state   = S_D_FIND;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_height <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_height <= n_height;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_start    <= n_start;
        r_cnt_mask <= n_cnt_mask;
        r_visited  <= n_visited;
        r_cand     <= n_cand;
        r_cur_d    <= n_cur_d;
    end

    amgt_adj_ram #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_clr   (adj_clr),
        .o_rdata (adj_rdata)
    );

    amgt_list_ram #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_re    (lst_re),
        .i_raddr (lst_raddr),
        .i_we    (lst_we),
        .i_waddr (lst_waddr),
        .i_wdata (lst_wdata),
        .o_rdata (lst_rdata)
    );

    amgt_result_buf u_result_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (res_req),
        .i_stall    (i_out_stall),
        .o_room     (res_room),
        .o_valid    (o_out_valid),
        .o_vertex   (o_vertex),
        .o_distance (o_distance),
        .o_last     (o_last),
        .o_status   (o_status)
    );

endmodule

### hw/rtl/amgt_adj_ram.sv
// ----------------------------------------------------------------------------
// amgt_adj_ram
// Adjacency row memory, one row per vertex, with per-row valid bits so that
// a clear empties the whole matrix at once.
// ----------------------------------------------------------------------------
module amgt_adj_ram #(
    parameter int MAX_VERTICES = amgt_pkg::MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_re,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_raddr,
    input  logic                            i_we,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_waddr,
    input  logic [MAX_VERTICES-1:0]         i_wdata,
    input  logic                            i_clr,
    output logic [MAX_VERTICES-1:0]         o_rdata
);
    import amgt_pkg::*;

    logic [MAX_VERTICES-1:0] r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [MAX_VERTICES-1:0] r_rdata;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_clr) begin
                r_row_vld <= '0;
            end else if (i_we) begin
                r_row_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_row_vld[i_raddr];
            end
        end
    end

    // a row never written since the last clear reads as empty
    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

### hw/rtl/amgt_list_ram.sv
// ----------------------------------------------------------------------------
// amgt_list_ram
// Entry memory shared by the breadth-first queue and the depth-first stack.
// ----------------------------------------------------------------------------
module amgt_list_ram #(
    parameter int MAX_VERTICES = amgt_pkg::MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_re,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_raddr,
    input  logic                            i_we,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_waddr,
    input  amgt_pkg::t_entry                i_wdata,
    output amgt_pkg::t_entry                o_rdata
);
    import amgt_pkg::*;

    t_entry r_mem [MAX_VERTICES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/amgt_result_buf.sv
// ----------------------------------------------------------------------------
// amgt_result_buf
// Holds the newest result until the next one or the end of the traversal is
// known, so the final word can carry last, then feeds the output register.
// ----------------------------------------------------------------------------
module amgt_result_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  amgt_pkg::t_res_req          i_req,
    input  logic                        i_stall,
    output logic                        o_room,
    output logic                        o_valid,
    output logic [amgt_pkg::VW-1:0]     o_vertex,
    output logic [amgt_pkg::DW-1:0]     o_distance,
    output logic                        o_last,
    output logic                        o_status
);
    import amgt_pkg::*;

    logic          r_hold_v;
    logic [VW-1:0] r_hold_vertex;
    logic [DW-1:0] r_hold_distance;
    logic          r_hold_status;

    logic          r_out_v;
    logic [VW-1:0] r_out_vertex;
    logic [DW-1:0] r_out_distance;
    logic          r_out_last;
    logic          r_out_status;

    logic out_free;
    logic move;

    assign out_free = !r_out_v || !i_stall;
    assign o_room   = !r_hold_v || out_free;
    assign move     = (i_req.push || i_req.flush) && r_hold_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (move) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            if (i_req.push) begin
                r_hold_v <= 1'b1;
            end else if (i_req.flush) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_vertex   <= r_hold_vertex;
            r_out_distance <= r_hold_distance;
            r_out_status   <= r_hold_status;
            r_out_last     <= i_req.flush;
        end
        if (i_req.push) begin
            r_hold_vertex   <= i_req.vertex;
            r_hold_distance <= i_req.distance;
            r_hold_status   <= i_req.status;
        end
    end

    assign o_valid    = r_out_v;
    assign o_vertex   = r_out_vertex;
    assign o_distance = r_out_distance;
    assign o_last     = r_out_last;
    assign o_status   = r_out_status;

endmodule
